[rtl/core/cbc_pkg.sv]
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types, constants and the colour classifier for the blob centroid core.
// ----------------------------------------------------------------------------
package cbc_pkg;

	localparam int DEF_MAX_COLS = 2048;
	localparam int DEF_MAX_ROWS = 2048;

	localparam int NUM_CLASS  = 5;
	localparam int COUNT_W    = 23;
	localparam int SUM_W      = 33;
	localparam int COORD_W    = 11;
	localparam int REM_W      = COUNT_W + 1;
	localparam int DIV_STEPS  = SUM_W;
	localparam int CNT_W      = 6;
	localparam int RAD_W      = 11;
	localparam int LIM_W      = 30;
	localparam int SQ_W       = 2 * RAD_W;
	localparam int PROD_W     = SQ_W + 9;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
	localparam logic [COORD_W-1:0] COORD_MAX = '1;
	localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(DIV_STEPS - 1);

	typedef enum logic [2:0] {
		CLS_RED    = 3'd0,
		CLS_BLUE   = 3'd1,
		CLS_GREEN  = 3'd2,
		CLS_YELLOW = 3'd3,
		CLS_PINK   = 3'd4
	} cls_t;

	typedef struct packed {
		logic [10:0] pixel_x;
		logic [10:0] pixel_y;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic        end_of_frame;
	} pixel_t;

	typedef struct packed {
		logic [2:0]  color_class;
		logic [10:0] center_x;
		logic [10:0] center_y;
		logic [10:0] radius;
		logic [22:0] pixel_count;
		logic        class_empty;
		logic        last_result;
	} result_t;

	typedef struct packed {
		logic       accum;
		logic       load;
		logic       step;
		logic       clear;
		logic [2:0] idx;
	} cmd_t;

	// first matching box wins, hit low when no box fits
	function automatic logic [3:0] classify(input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r);
		logic [3:0] res;
		res = {1'b0, CLS_RED};
		if (b < 8'd60 && g < 8'd60 && r > 8'd150) res = {1'b1, CLS_RED};
		else if (b > 8'd100 && g < 8'd65 && r < 8'd65) res = {1'b1, CLS_BLUE};
		else if (b < 8'd50 && g > 8'd100 && r < 8'd50) res = {1'b1, CLS_GREEN};
		else if (b < 8'd60 && g > 8'd150 && r > 8'd150) res = {1'b1, CLS_YELLOW};
		else if (b > 8'd200 && g < 8'd180 && r > 8'd200) res = {1'b1, CLS_PINK};
		return res;
	endfunction

endpackage

[rtl/core/cbc_ctrl.sv]
// ----------------------------------------------------------------------------
// cbc_ctrl
// Sequencer: pixel intake, per-class divide phase and result hand-off.
// ----------------------------------------------------------------------------
module cbc_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pixel_valid,
	input  logic         end_of_frame,
	input  logic         result_stall,
	output logic         idle,
	output logic         result_valid,
	output cbc_pkg::cmd_t cmd
);
	import cbc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOAD = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0]       idx_q;
	logic             accept;
	logic             out_xfer;
	logic             last_cls;

	assign idle         = (state_q == S_IDLE);
	assign result_valid = (state_q == S_OUT);
	assign accept       = idle && pixel_valid;
	assign out_xfer     = result_valid && !result_stall;
	assign last_cls     = (idx_q == 3'(CLS_PINK));

	assign cmd.accum = accept;
	assign cmd.load  = (state_q == S_LOAD);
	assign cmd.step  = (state_q == S_DIV);
	assign cmd.clear = out_xfer && last_cls;
	assign cmd.idx   = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && end_of_frame) begin
						idx_q   <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == DIV_LAST) state_q <= S_OUT;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_OUT: begin
					if (out_xfer) begin
						if (last_cls) state_q <= S_IDLE;
						else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_LOAD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// results only after a full divide run
	a_out_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (cnt_q == DIV_LAST))
		else $error("result shown before divide finished");

	a_clear_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (state_q == S_IDLE))
		else $error("accumulators cleared outside the final transfer");

	a_load_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |=> (state_q == S_DIV && cnt_q == '0))
		else $error("divide not started after load");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!idle |-> (idx_q <= 3'(CLS_PINK)))
		else $error("class index out of range");

endmodule

[rtl/core/cbc_dp.sv]
// ----------------------------------------------------------------------------
// cbc_dp
// Accumulators, restoring dividers for the centres and bitwise radius search.
// ----------------------------------------------------------------------------
module cbc_dp #(
	parameter int MAX_COLS = cbc_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = cbc_pkg::DEF_MAX_ROWS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cbc_pkg::cmd_t    cmd,
	input  cbc_pkg::pixel_t  pixel,
	output cbc_pkg::result_t result
);
	import cbc_pkg::*;

	localparam int LIM_CMP_W = 14;

	logic [COUNT_W-1:0] cnt_q  [NUM_CLASS];
	logic [SUM_W-1:0]   sumx_q [NUM_CLASS];
	logic [SUM_W-1:0]   sumy_q [NUM_CLASS];

	logic [3:0]         cls_hit;
	logic [2:0]         rd_idx;
	logic               in_frame;
	logic [SUM_W:0]     addx;
	logic [SUM_W:0]     addy;

	logic [COUNT_W-1:0] n_q;
	logic [REM_W-1:0]   remx_q, remy_q;
	logic [SUM_W-1:0]   qx_q, qy_q;
	logic [REM_W-1:0]   tx, ty;
	logic               gex, gey;

	logic [LIM_W-1:0]   lim_q;
	logic [SQ_W-1:0]    sq_q;
	logic [RAD_W-1:0]   r_q, rmask_q, rtry;
	logic               rph_q;
	logic [PROD_W-1:0]  prod;

	assign cls_hit  = classify(pixel.blue, pixel.green, pixel.red);
	assign in_frame = ({3'b0, pixel.pixel_x} < LIM_CMP_W'(MAX_COLS)) &&
		({3'b0, pixel.pixel_y} < LIM_CMP_W'(MAX_ROWS));
	assign rd_idx   = cmd.accum ? cls_hit[2:0] : cmd.idx;
	assign addx     = {1'b0, sumx_q[rd_idx]} + (SUM_W+1)'(pixel.pixel_x);
	assign addy     = {1'b0, sumy_q[rd_idx]} + (SUM_W+1)'(pixel.pixel_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASS; i++) begin
				cnt_q[i]  <= '0;
				sumx_q[i] <= '0;
				sumy_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < NUM_CLASS; i++) begin
				cnt_q[i]  <= '0;
				sumx_q[i] <= '0;
				sumy_q[i] <= '0;
			end
		end else if (cmd.accum && in_frame && cls_hit[3] && cnt_q[rd_idx] != COUNT_MAX) begin
			cnt_q[rd_idx]  <= cnt_q[rd_idx] + 1'b1;
			sumx_q[rd_idx] <= addx[SUM_W] ? SUM_MAX : addx[SUM_W-1:0];
			sumy_q[rd_idx] <= addy[SUM_W] ? SUM_MAX : addy[SUM_W-1:0];
		end
	end

	// one quotient bit per cycle
	assign tx   = {remx_q[REM_W-2:0], qx_q[SUM_W-1]};
	assign ty   = {remy_q[REM_W-2:0], qy_q[SUM_W-1]};
	assign gex  = tx >= {1'b0, n_q};
	assign gey  = ty >= {1'b0, n_q};
	assign rtry = r_q | rmask_q;
	assign prod = PROD_W'(sq_q) * PROD_W'(314);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q     <= cnt_q[rd_idx];
			qx_q    <= sumx_q[rd_idx];
			qy_q    <= sumy_q[rd_idx];
			remx_q  <= '0;
			remy_q  <= '0;
			lim_q   <= LIM_W'(cnt_q[rd_idx]) * LIM_W'(100);
			r_q     <= '0;
			rmask_q <= {1'b1, {(RAD_W-1){1'b0}}};
			rph_q   <= 1'b0;
			sq_q    <= '0;
		end else if (cmd.step) begin
			remx_q <= gex ? tx - {1'b0, n_q} : tx;
			remy_q <= gey ? ty - {1'b0, n_q} : ty;
			qx_q   <= {qx_q[SUM_W-2:0], gex};
			qy_q   <= {qy_q[SUM_W-2:0], gey};
			// radius: square on one cycle, scale and compare on the next
			if (rmask_q != '0) begin
				if (!rph_q) begin
					sq_q  <= SQ_W'(rtry) * SQ_W'(rtry);
					rph_q <= 1'b1;
				end else begin
					if (prod <= PROD_W'(lim_q)) r_q <= rtry;
					rmask_q <= rmask_q >> 1;
					rph_q   <= 1'b0;
				end
			end
		end
	end

	logic empty;
	assign empty = (n_q == '0);

	always_comb begin
		result.color_class = cmd.idx;
		result.center_x    = empty ? '0 :
			((|qx_q[SUM_W-1:COORD_W]) ? COORD_MAX : qx_q[COORD_W-1:0]);
		result.center_y    = empty ? '0 :
			((|qy_q[SUM_W-1:COORD_W]) ? COORD_MAX : qy_q[COORD_W-1:0]);
		result.radius      = empty ? '0 : r_q;
		result.pixel_count = n_q;
		result.class_empty = empty;
		result.last_result = (cmd.idx == 3'(CLS_PINK));
	end

endmodule

[rtl/core/color_blob_centroid_core.sv]
// Operation: a non-final pixel is accumulated when accepted; the final
// pixel of a frame starts five result rounds (load, 33-step divide, output).
// Throughput: 1 pixel per cycle inside a frame; at the frame end, pixel_stall
// stays high through all rounds; one bit-serial divider is shared over classes.
// Reset: asynchronous, clears sequencer state and all class accumulators.
// ----------------------------------------------------------------------------
// color_blob_centroid_core
// Colour box classifier with per-class centroid and radius reporting.
// ----------------------------------------------------------------------------
module color_blob_centroid_core #(
	parameter int MAX_COLS = cbc_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = cbc_pkg::DEF_MAX_ROWS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  cbc_pkg::pixel_t  pixel,
	output logic             result_valid,
	input  logic             result_stall,
	output cbc_pkg::result_t result
);
	import cbc_pkg::*;

	cmd_t cmd;
	logic idle;

	assign pixel_stall = !idle;

	cbc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.end_of_frame (pixel.end_of_frame),
		.result_stall (result_stall),
		.idle         (idle),
		.result_valid (result_valid),
		.cmd          (cmd)
	);

	cbc_dp #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pixel  (pixel),
		.result (result)
	);

endmodule

[sim/color_blob_centroid_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_blob_centroid_core_tb
// Drives pixel frames with random gaps, predicts the per-class centroid,
// radius and count for every frame end, and checks each result transfer.
// ----------------------------------------------------------------------------
module color_blob_centroid_core_tb;
	import cbc_pkg::*;

	localparam int COLS = 2048;
	localparam int ROWS = 2048;

	class blob_scoreboard;
		logic [22:0] count_acc [NUM_CLASS];
		logic [32:0] xsum_acc [NUM_CLASS];
		logic [32:0] ysum_acc [NUM_CLASS];
		result_t pending_results [$];
		int errors;

		function new();
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			for (int i = 0; i < NUM_CLASS; i++) begin
				count_acc[i] = '0;
				xsum_acc[i] = '0;
				ysum_acc[i] = '0;
			end
		endfunction

		function logic [32:0] sat_sum(logic [32:0] a, logic [10:0] b);
			logic [33:0] s;
			s = {1'b0, a} + 34'(b);
			return s[33] ? SUM_MAX : s[32:0];
		endfunction

		function logic [10:0] blob_radius(logic [22:0] n);
			logic [63:0] lim;
			logic [63:0] t;
			logic [10:0] r;
			lim = 64'd100 * 64'(n);
			r = '0;
			for (int b = 10; b >= 0; b--) begin
				t = 64'(r | (11'd1 << b));
				if (64'd314 * t * t <= lim) r = t[10:0];
			end
			return r;
		endfunction

		function void note_pixel(pixel_t p);
			logic [3:0] hit;
			logic [32:0] cx;
			logic [32:0] cy;
			result_t res;
			int c;
			hit = 4'h0;
			if (p.pixel_x < COLS && p.pixel_y < ROWS) begin
				if (p.blue < 60 && p.green < 60 && p.red > 150) hit = {1'b1, CLS_RED};
				else if (p.blue > 100 && p.green < 65 && p.red < 65) hit = {1'b1, CLS_BLUE};
				else if (p.blue < 50 && p.green > 100 && p.red < 50) hit = {1'b1, CLS_GREEN};
				else if (p.blue < 60 && p.green > 150 && p.red > 150)
					hit = {1'b1, CLS_YELLOW};
				else if (p.blue > 200 && p.green < 180 && p.red > 200)
					hit = {1'b1, CLS_PINK};
			end
			c = int'(hit[2:0]);
			if (hit[3] && count_acc[c] != COUNT_MAX) begin
				count_acc[c]++;
				xsum_acc[c] = sat_sum(xsum_acc[c], p.pixel_x);
				ysum_acc[c] = sat_sum(ysum_acc[c], p.pixel_y);
			end
			if (!p.end_of_frame) return;
			for (int i = 0; i < NUM_CLASS; i++) begin
				res = '0;
				res.color_class = cls_t'(i);
				res.pixel_count = count_acc[i];
				res.class_empty = (count_acc[i] == 0);
				res.last_result = (i == NUM_CLASS - 1);
				if (count_acc[i] != 0) begin
					cx = xsum_acc[i] / 33'(count_acc[i]);
					cy = ysum_acc[i] / 33'(count_acc[i]);
					res.center_x = (cx > 33'(COORD_MAX)) ? COORD_MAX : cx[10:0];
					res.center_y = (cy > 33'(COORD_MAX)) ? COORD_MAX : cy[10:0];
					res.radius = blob_radius(count_acc[i]);
				end
				pending_results.push_back(res);
			end
			clear_frame();
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got);
				errors++;
				return;
			end
			exp = pending_results.pop_front();
			if (got.color_class !== exp.color_class) report("color_class", exp.color_class, got.color_class);
			if (got.center_x !== exp.center_x) report("center_x", exp.center_x, got.center_x);
			if (got.center_y !== exp.center_y) report("center_y", exp.center_y, got.center_y);
			if (got.radius !== exp.radius) report("radius", exp.radius, got.radius);
			if (got.pixel_count !== exp.pixel_count) report("pixel_count", exp.pixel_count, got.pixel_count);
			if (got.class_empty !== exp.class_empty) report("class_empty", exp.class_empty, got.class_empty);
			if (got.last_result !== exp.last_result) report("last_result", exp.last_result, got.last_result);
		endfunction

		function void report(string fld, logic [31:0] e, logic [31:0] a);
			$display("%0t: %s expected %0d actual %0d", $realtime, fld, e, a);
			errors++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic pixel_valid;
	logic pixel_stall;
	pixel_t pixel;
	logic result_valid;
	logic result_stall;
	result_t result;

	blob_scoreboard sb;

	color_blob_centroid_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// colour drawn to hit a given box, or anything for noise
	function automatic pixel_t make_pixel(int kind, bit eof);
		pixel_t p;
		p.pixel_x = 11'($urandom_range(0, 2047));
		p.pixel_y = 11'($urandom_range(0, 2047));
		p.end_of_frame = eof;
		case (kind)
			CLS_RED: begin
				p.blue = 8'($urandom_range(0, 59)); p.green = 8'($urandom_range(0, 59));
				p.red = 8'($urandom_range(151, 255));
			end
			CLS_BLUE: begin
				p.blue = 8'($urandom_range(101, 255)); p.green = 8'($urandom_range(0, 64));
				p.red = 8'($urandom_range(0, 64));
			end
			CLS_GREEN: begin
				p.blue = 8'($urandom_range(0, 49)); p.green = 8'($urandom_range(101, 255));
				p.red = 8'($urandom_range(0, 49));
			end
			CLS_YELLOW: begin
				p.blue = 8'($urandom_range(0, 59)); p.green = 8'($urandom_range(151, 255));
				p.red = 8'($urandom_range(151, 255));
			end
			CLS_PINK: begin
				p.blue = 8'($urandom_range(201, 255)); p.green = 8'($urandom_range(0, 179));
				p.red = 8'($urandom_range(201, 255));
			end
			default: begin
				p.blue = 8'($urandom); p.green = 8'($urandom); p.red = 8'($urandom);
			end
		endcase
		return p;
	endfunction

	// valid stays up after a transfer until the next falling edge decides
	task automatic send_pixel(pixel_t p);
		int w;
		w = $urandom_range(0, 16) * int'($urandom_range(0, 3) != 0);
		@(negedge clk);
		if (w != 0) begin
			pixel_valid <= 1'b0;
			repeat (w) @(negedge clk);
		end
		pixel <= p;
		pixel_valid <= 1'b1;
		do @(posedge clk); while (pixel_stall);
		sb.note_pixel(p);
	endtask

	task automatic send_raw(logic [10:0] x, logic [10:0] y, logic [7:0] b, logic [7:0] g,
			logic [7:0] r, bit eof);
		pixel_t p;
		p.pixel_x = x; p.pixel_y = y; p.blue = b; p.green = g; p.red = r;
		p.end_of_frame = eof;
		send_pixel(p);
	endtask

	// result side: random stall per transfer, with quiet stretches
	initial begin
		result_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			int w;
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			@(negedge clk);
			if (w != 0) begin
				result_stall <= 1'b1;
				repeat (w) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			sb.check_result(result);
		end
	end

	initial begin
		int n;
		sb = new();
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty frame, then edges of every box and coordinate extremes
		send_raw(11'd0, 11'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_raw(11'd0, 11'd0, 8'd59, 8'd59, 8'd151, 1'b0);
		send_raw(11'd2047, 11'd2047, 8'd0, 8'd0, 8'd255, 1'b0);
		send_raw(11'd2047, 11'd0, 8'd101, 8'd64, 8'd64, 1'b0);
		send_raw(11'd0, 11'd2047, 8'd255, 8'd0, 8'd0, 1'b0);
		send_raw(11'd5, 11'd9, 8'd49, 8'd101, 8'd49, 1'b0);
		send_raw(11'd1, 11'd1, 8'd0, 8'd255, 8'd0, 1'b0);
		send_raw(11'd100, 11'd200, 8'd59, 8'd151, 8'd151, 1'b0);
		send_raw(11'd300, 11'd400, 8'd0, 8'd255, 8'd255, 1'b0);
		send_raw(11'd1000, 11'd1024, 8'd201, 8'd179, 8'd201, 1'b0);
		send_raw(11'd2047, 11'd2047, 8'd255, 8'd0, 8'd255, 1'b0);
		// boundary misses, then a matching final pixel
		send_raw(11'd7, 11'd7, 8'd60, 8'd59, 8'd151, 1'b0);
		send_raw(11'd7, 11'd7, 8'd100, 8'd64, 8'd64, 1'b0);
		send_raw(11'd7, 11'd7, 8'd200, 8'd179, 8'd201, 1'b0);
		send_raw(11'd7, 11'd7, 8'd128, 8'd128, 8'd128, 1'b0);
		send_raw(11'd33, 11'd44, 8'd10, 8'd10, 8'd200, 1'b1);
		// no-match final pixel on a populated frame
		for (int i = 0; i < 5; i++) send_pixel(make_pixel(i, 1'b0));
		send_raw(11'd2, 11'd3, 8'd128, 8'd128, 8'd128, 1'b1);

		// random frames of mostly matching pixels
		n = 0;
		while (n < 130) begin
			int len;
			len = $urandom_range(1, 25);
			for (int i = 0; i < len; i++) begin
				send_pixel(make_pixel($urandom_range(0, 6), i == len - 1));
				n++;
			end
		end
		@(negedge clk);
		pixel_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
